>>> design/query_message_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// query message deframer assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef QUERY_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH
`define QUERY_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define QMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define QMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> design/qmd_pkg.sv
// ----------------------------------------------------------------------------
// qmd_pkg
// types, section codes and field widths for the query message deframer
// ----------------------------------------------------------------------------
`default_nettype none

package qmd_pkg;

  // section codes
  localparam logic [3:0] SEC_LEN    = 4'd0;
  localparam logic [3:0] SEC_FLOW   = 4'd1;
  localparam logic [3:0] SEC_PID    = 4'd2;
  localparam logic [3:0] SEC_PATHSZ = 4'd3;
  localparam logic [3:0] SEC_PATH   = 4'd4;
  localparam logic [3:0] SEC_CHSZ   = 4'd5;
  localparam logic [3:0] SEC_CH     = 4'd6;
  localparam logic [3:0] SEC_SHSZ   = 4'd7;
  localparam logic [3:0] SEC_SH     = 4'd8;
  localparam logic [3:0] SEC_OBJSZ  = 4'd9;
  localparam logic [3:0] SEC_CERTSZ = 4'd10;
  localparam logic [3:0] SEC_CERT   = 4'd11;
  localparam logic [3:0] SEC_TRAIL  = 4'd12;

  // field sizes in bytes
  localparam logic [31:0] HDR_BYTES    = 32'd8;
  localparam logic [31:0] SIZE_BYTES   = 32'd4;
  localparam logic [31:0] CERTSZ_BYTES = 32'd3;

  // status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_TRUNC = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } qmd_in_t;

  typedef struct packed {
    logic [3:0]  section;
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        payload_last;
    logic [63:0] declared_length;
    logic [63:0] flow_handle;
    logic [63:0] process_id;
    logic        message_done;
    logic        status;
  } qmd_out_t;

  // byte count of a header or size field, zero for payload and trailing
  function automatic logic [31:0] fld_width(input logic [3:0] sec);
    logic [31:0] w;
    w = '0;
    if (sec <= SEC_PID) begin
      w = HDR_BYTES;
    end else if (sec == SEC_PATHSZ || sec == SEC_CHSZ || sec == SEC_SHSZ ||
                 sec == SEC_OBJSZ) begin
      w = SIZE_BYTES;
    end else if (sec == SEC_CERTSZ) begin
      w = CERTSZ_BYTES;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/query_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// query_message_deframer_unit
// byte-wide query message parser with section tagging and end-of-message report
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_data carry one message byte per transfer, last_byte marking
//   the end of a message. out_valid/out_data carry one result per byte: the
//   byte, its section code and payload marks; on the final byte the three
//   header fields and a truncation status are added.
//   Path: a byte taken into the input register passes the section state
//   update into the result register once that register is free to take
//   it, and shows on out_* from then on.
//   Throughput: one byte per cycle while out_stall is low; the section
//   state update between the input and result registers is combinational.
//   Stall: out_stall holds the result register; one more byte may sit in
//   the input register, after which in_stall is raised. No byte is dropped.
//   Reset: rst_n low at a clock edge empties both registers and returns the
//   parser to the length field. After each final byte the parser goes back
//   to that state by itself, so the next byte opens a new message.
// ----------------------------------------------------------------------------
`default_nettype none

module query_message_deframer_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire qmd_pkg::qmd_in_t in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output qmd_pkg::qmd_out_t     out_data,
  input  wire logic             out_stall
);

  // pipeline registers
  logic               s1_valid_r;
  qmd_pkg::qmd_in_t   s1_data_r;
  logic               out_valid_r;
  qmd_pkg::qmd_out_t  out_data_r;
  logic               advance;

  // parser state
  logic [3:0]  sec_r,  sec_nxt;
  logic [31:0] left_r, left_nxt;
  logic [63:0] asm_r,  asm_nxt;
  logic [63:0] len_r,  len_nxt;
  logic [63:0] flow_r, flow_nxt;
  logic [63:0] pid_r,  pid_nxt;
  logic [31:0] obj_r,  obj_nxt;

  // per-byte working values
  logic [3:0]        sec_eff;
  logic [31:0]       left_dec;
  logic [63:0]       asm_shift;
  logic [31:0]       size32;
  logic              enter;
  logic [3:0]        enter_sec;
  logic [31:0]       enter_cnt;
  logic [7:0]        b;
  qmd_pkg::qmd_out_t res;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // section update for the byte in the input register
  always_comb begin
    b        = s1_data_r.data_byte;
    sec_eff  = (sec_r > qmd_pkg::SEC_TRAIL) ? qmd_pkg::SEC_TRAIL : sec_r;
    left_dec = (left_r != '0) ? left_r - 32'd1 : '0;
    if (sec_eff == qmd_pkg::SEC_CERTSZ) begin
      asm_shift = {40'd0, asm_r[15:0], b};
      size32    = asm_shift[31:0];
    end else begin
      asm_shift = {b, asm_r[63:8]};
      size32    = asm_shift[63:32];
    end

    sec_nxt   = sec_r;
    left_nxt  = left_r;
    asm_nxt   = asm_r;
    len_nxt   = len_r;
    flow_nxt  = flow_r;
    pid_nxt   = pid_r;
    obj_nxt   = obj_r;
    enter     = 1'b0;
    enter_sec = sec_eff;
    enter_cnt = '0;
    res       = '0;

    // cert object bound counts from the cert size field onward
    if (sec_eff >= qmd_pkg::SEC_CERTSZ && obj_r != '0) begin
      obj_nxt = obj_r - 32'd1;
    end

    if (sec_eff == qmd_pkg::SEC_TRAIL) begin
      sec_nxt = qmd_pkg::SEC_TRAIL;
    end else if (sec_eff inside {qmd_pkg::SEC_PATH, qmd_pkg::SEC_CH,
                                 qmd_pkg::SEC_SH, qmd_pkg::SEC_CERT}) begin
      // payload byte
      res.payload_valid = 1'b1;
      left_nxt          = left_dec;
      if (left_dec == '0) begin
        res.payload_last = 1'b1;
        enter            = 1'b1;
        enter_sec        = (sec_eff == qmd_pkg::SEC_CERT) ? qmd_pkg::SEC_TRAIL
                                                          : sec_eff + 4'd1;
      end
    end else begin
      // header or size field byte
      asm_nxt  = asm_shift;
      left_nxt = left_dec;
      if (left_dec == '0) begin
        enter = 1'b1;
        if (sec_eff <= qmd_pkg::SEC_PID) begin
          case (sec_eff)
            qmd_pkg::SEC_LEN:  len_nxt  = asm_shift;
            qmd_pkg::SEC_FLOW: flow_nxt = asm_shift;
            default:           pid_nxt  = asm_shift;
          endcase
          enter_sec = sec_eff + 4'd1;
        end else if (sec_eff == qmd_pkg::SEC_OBJSZ) begin
          obj_nxt   = size32;
          enter_sec = qmd_pkg::SEC_CERTSZ;
        end else if (size32 != '0) begin
          enter_sec = sec_eff + 4'd1;
          enter_cnt = size32;
        end else begin
          // empty payload skips ahead
          enter_sec = (sec_eff == qmd_pkg::SEC_CERTSZ) ? qmd_pkg::SEC_TRAIL
                                                       : sec_eff + 4'd2;
        end
      end
    end

    // entering a new section
    if (enter) begin
      sec_nxt  = enter_sec;
      asm_nxt  = '0;
      left_nxt = (qmd_pkg::fld_width(enter_sec) != '0) ? qmd_pkg::fld_width(enter_sec)
                                                        : enter_cnt;
    end

    res.section  = sec_eff;
    res.out_byte = b;

    // end of message report and return to the start state
    if (s1_data_r.last_byte) begin
      res.message_done    = 1'b1;
      res.declared_length = len_nxt;
      res.flow_handle     = flow_nxt;
      res.process_id      = pid_nxt;
      res.status          = (sec_nxt != qmd_pkg::SEC_TRAIL || obj_nxt != '0)
                            ? qmd_pkg::ST_TRUNC : qmd_pkg::ST_OK;
      sec_nxt  = qmd_pkg::SEC_LEN;
      left_nxt = qmd_pkg::HDR_BYTES;
      asm_nxt  = '0;
      len_nxt  = '0;
      flow_nxt = '0;
      pid_nxt  = '0;
      obj_nxt  = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // parser state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= qmd_pkg::SEC_LEN;
      left_r <= qmd_pkg::HDR_BYTES;
      asm_r  <= '0;
      len_r  <= '0;
      flow_r <= '0;
      pid_r  <= '0;
      obj_r  <= '0;
    end else if (advance) begin
      sec_r  <= sec_nxt;
      left_r <= left_nxt;
      asm_r  <= asm_nxt;
      len_r  <= len_nxt;
      flow_r <= flow_nxt;
      pid_r  <= pid_nxt;
      obj_r  <= obj_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/qmd_checker.sv
// ----------------------------------------------------------------------------
// qmd_checker
// port-level checks on the query message deframer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "query_message_deframer_unit_assert.svh"

module qmd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire qmd_pkg::qmd_out_t out_data,
  input wire logic              out_stall
);

  // a held result stays offered and unchanged
  `QMD_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
  `QMD_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall, $stable(out_data))

  // with an empty result register the input side never stalls
  `QMD_ASSERT_IMPL(a_no_stall_when_empty, !out_valid, !in_stall)

  // report fields are zero except at the end of a message
  `QMD_ASSERT_IMPL(a_report_zero, out_valid && !out_data.message_done,
                   out_data.declared_length == '0 && out_data.flow_handle == '0 && out_data.process_id == '0 && out_data.status == qmd_pkg::ST_OK)

  // a payload end mark only on a payload transfer
  `QMD_ASSERT_IMPL(a_last_in_payload, out_valid && out_data.payload_last,
                   out_data.payload_valid)

endmodule

bind query_message_deframer_unit qmd_checker u_qmd_checker (.*);

`default_nettype wire
